// File: hdl/mspid_pkg.sv
`timescale 1ns / 1ps

package mspid_pkg;

    // Fixed point and limits
    localparam int FRAC_BITS = 8;
    localparam int DUTY_MAX  = 255;

    // Field widths
    localparam int CMD_W     = 1;
    localparam int CNT_W     = 16;
    localparam int RPM_W     = 24;
    localparam int ERR_W     = RPM_W + 1;
    localparam int COEF_W    = 16;
    localparam int DB_W      = 8;
    localparam int SCALE_W   = 16;
    localparam int DRIVE_W   = 32;
    localparam int DUTY_W    = 8;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    // Serial multiplier: one multiplier bit per cycle
    localparam int DIGITS    = 16;
    localparam int BIT_CNT_W = $clog2(DIGITS);
    localparam int ACC_W     = 48;
    localparam int SUM_W     = ACC_W - FRAC_BITS;
    localparam int DSUM_W    = SUM_W + 1;
    localparam int TERM_W    = 2;

    localparam logic [TERM_W-1:0] TERM_NOW  = 2'd0;
    localparam logic [TERM_W-1:0] TERM_LAST = 2'd1;
    localparam logic [TERM_W-1:0] TERM_BL   = 2'd2;

    // Saturation bounds
    localparam logic signed [31:0] RPM_MAX = 32'sd8388607;
    localparam logic signed [31:0] RPM_MIN = -32'sd8388608;
    localparam logic signed [DSUM_W-1:0] DRIVE_MAX = DSUM_W'(64'sd2147483647);
    localparam logic signed [DSUM_W-1:0] DRIVE_MIN = DSUM_W'(-64'sd2147483648);
    localparam logic [DRIVE_W-1:0] DRIVE_LIM = DRIVE_W'(DUTY_MAX << FRAC_BITS);

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd427;

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_NOW         = 3'd0,
        REG_COEF_LAST        = 3'd1,
        REG_COEF_BEFORE_LAST = 3'd2,
        REG_DEAD_BAND        = 3'd3,
        REG_COUNT_TO_RPM     = 3'd4
    } cfg_idx_t;

    // Sequencer states
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MEAS  = 6'b000010,
        ST_ERR   = 6'b000100,
        ST_PID   = 6'b001000,
        ST_DRIVE = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

endpackage

// File: hdl/motor_speed_incremental_pid_top.sv
`timescale 1ns / 1ps

// Channel   Handshake             Beat contents
// ------    --------------------  ----------------------------------------------
// in        in_valid / in_ready   cmd, encoder_count, target_rpm
// out       out_valid / out_ready drive_fwd, drive_rev, pwm_duty, measured_rpm
// cfg       cfg_wr_en (no wait)   cfg_addr, cfg_wdata
//
// A sample beat runs from accept through the bit-serial multiplier for the RPM
// scale, the error step, the three PID products (one coefficient bit per cycle),
// the drive step and the result step; the next beat is accepted only back in idle.
// A stop beat goes from accept straight to the result step. Reset clears coefficients,
// dead band and PID state and sets count_to_rpm to 427. A stalled result waits in the
// output register; the sequencer holds in its last state until that register is free.

module motor_speed_incremental_pid_top
(
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   cfg_wr_en,
    input  logic [mspid_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  logic [mspid_pkg::CFG_W-1:0]            cfg_wdata,

    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [mspid_pkg::CMD_W-1:0]            cmd,
    input  logic signed [mspid_pkg::CNT_W-1:0]     encoder_count,
    input  logic signed [mspid_pkg::RPM_W-1:0]     target_rpm,

    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   drive_fwd,
    output logic                                   drive_rev,
    output logic [mspid_pkg::DUTY_W-1:0]           pwm_duty,
    output logic signed [mspid_pkg::RPM_W-1:0]     measured_rpm
);
    import mspid_pkg::*;

    state_t state_reg, state_next;

    // Configuration registers
    logic signed [COEF_W-1:0]  coef_now_reg, coef_last_reg, coef_bl_reg;
    logic [DB_W-1:0]           dead_band_reg;
    logic [SCALE_W-1:0]        count_to_rpm_reg;

    // PID state
    logic signed [DRIVE_W-1:0] prev_drive_reg;
    logic signed [ERR_W-1:0]   err_last_reg, err_bl_reg;

    // Working registers
    logic                      stop_reg;
    logic signed [RPM_W-1:0]   target_reg;
    logic signed [RPM_W-1:0]   meas_reg;
    logic signed [ERR_W-1:0]   err_now_reg;
    logic signed [ACC_W-1:0]   acc_reg, mcand_reg;
    logic [COEF_W-1:0]         mplier_reg;
    logic [BIT_CNT_W-1:0]      bit_cnt_reg;
    logic [TERM_W-1:0]         term_reg;
    logic signed [DRIVE_W-1:0] drive_reg;

    // Output register
    logic                      out_valid_reg;
    logic                      fwd_reg, rev_reg;
    logic [DUTY_W-1:0]         duty_reg;
    logic signed [RPM_W-1:0]   rpm_reg;

    logic                      in_fire, slot_free, last_bit, step_sub;
    logic signed [ACC_W-1:0]   addend, acc_step;
    logic signed [31:0]        prod32;
    logic signed [RPM_W-1:0]   meas_sat;
    logic signed [ERR_W-1:0]   err_calc;
    logic [TERM_W-1:0]         term_sel;
    logic signed [COEF_W-1:0]  op_coef;
    logic signed [ERR_W-1:0]   op_err;
    logic signed [SUM_W-1:0]   sum_sh;
    logic signed [DSUM_W-1:0]  drive_sum;
    logic signed [DRIVE_W-1:0] drive_sat;
    logic                      drive_neg, drive_nz, target_nz;
    logic [DRIVE_W-1:0]        mag, db_q, mag_db, mag_cl, duty_full;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // One step of the shift-add multiplier; the top coefficient bit weighs negative
    assign last_bit = (bit_cnt_reg == BIT_CNT_W'(DIGITS - 1));
    assign step_sub = last_bit && (state_reg == ST_PID);
    assign addend   = mplier_reg[0] ? mcand_reg : '0;
    assign acc_step = step_sub ? (acc_reg - addend) : (acc_reg + addend);

    // Speed saturation and error
    assign prod32   = acc_reg[31:0];
    always_comb
    begin
        if (prod32 > RPM_MAX)
            meas_sat = RPM_MAX[RPM_W-1:0];
        else if (prod32 < RPM_MIN)
            meas_sat = RPM_MIN[RPM_W-1:0];
        else
            meas_sat = prod32[RPM_W-1:0];
    end
    assign err_calc = ERR_W'(target_reg) - ERR_W'(meas_sat);

    // Operands of the next PID term
    assign term_sel = term_reg + TERM_W'(1);
    always_comb
    begin
        case (term_sel)
            TERM_LAST:
            begin
                op_coef = coef_last_reg;
                op_err  = err_last_reg;
            end
            TERM_BL:
            begin
                op_coef = coef_bl_reg;
                op_err  = err_bl_reg;
            end
            default:
            begin
                op_coef = coef_now_reg;
                op_err  = err_now_reg;
            end
        endcase
    end

    // Floor shift, accumulate onto previous drive, saturate to 32 bits
    assign sum_sh    = SUM_W'(acc_reg >>> FRAC_BITS);
    assign drive_sum = DSUM_W'(prev_drive_reg) + DSUM_W'(sum_sh);
    always_comb
    begin
        if (drive_sum > DRIVE_MAX)
            drive_sat = DRIVE_MAX[DRIVE_W-1:0];
        else if (drive_sum < DRIVE_MIN)
            drive_sat = DRIVE_MIN[DRIVE_W-1:0];
        else
            drive_sat = drive_sum[DRIVE_W-1:0];
    end

    // Dead band, clamp and duty on the magnitude; sign is kept apart
    assign drive_neg = drive_reg[DRIVE_W-1];
    assign drive_nz  = |drive_reg;
    assign target_nz = |target_reg;
    assign mag       = drive_neg ? (~drive_reg + DRIVE_W'(1)) : drive_reg;
    assign db_q      = DRIVE_W'(dead_band_reg) << FRAC_BITS;
    assign mag_db    = (drive_nz && (mag < db_q)) ? db_q : mag;
    assign mag_cl    = (mag_db > DRIVE_LIM) ? DRIVE_LIM : mag_db;
    assign duty_full = mag_cl >> FRAC_BITS;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_fire)
                    state_next = cmd[0] ? ST_FIN : ST_MEAS;
            ST_MEAS:
                if (last_bit)
                    state_next = ST_ERR;
            ST_ERR:
                state_next = ST_PID;
            ST_PID:
                if (last_bit && (term_reg == TERM_BL))
                    state_next = ST_DRIVE;
            ST_DRIVE:
                state_next = ST_FIN;
            ST_FIN:
                if (slot_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_now_reg     <= '0;
            coef_last_reg    <= '0;
            coef_bl_reg      <= '0;
            dead_band_reg    <= '0;
            count_to_rpm_reg <= SCALE_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_addr))
                REG_COEF_NOW:         coef_now_reg     <= cfg_wdata[COEF_W-1:0];
                REG_COEF_LAST:        coef_last_reg    <= cfg_wdata[COEF_W-1:0];
                REG_COEF_BEFORE_LAST: coef_bl_reg      <= cfg_wdata[COEF_W-1:0];
                REG_DEAD_BAND:        dead_band_reg    <= cfg_wdata[DB_W-1:0];
                REG_COUNT_TO_RPM:     count_to_rpm_reg <= cfg_wdata[SCALE_W-1:0];
                default:              ;
            endcase
        end
    end

    // Control and PID state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            prev_drive_reg <= '0;
            err_last_reg   <= '0;
            err_bl_reg     <= '0;
            stop_reg       <= 1'b0;
            bit_cnt_reg    <= '0;
            term_reg       <= TERM_NOW;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Result slot: filled by the last step, emptied on accept
            if ((state_reg == ST_FIN) && slot_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                    if (in_fire)
                    begin
                        stop_reg    <= cmd[0];
                        bit_cnt_reg <= '0;
                        if (cmd[0])
                        begin
                            prev_drive_reg <= '0;
                            err_last_reg   <= '0;
                            err_bl_reg     <= '0;
                        end
                    end
                ST_MEAS:
                    bit_cnt_reg <= bit_cnt_reg + BIT_CNT_W'(1);
                ST_ERR:
                begin
                    bit_cnt_reg <= '0;
                    term_reg    <= TERM_NOW;
                end
                ST_PID:
                begin
                    bit_cnt_reg <= bit_cnt_reg + BIT_CNT_W'(1);
                    if (last_bit)
                        term_reg <= term_sel;
                end
                ST_DRIVE:
                begin
                    prev_drive_reg <= drive_sat;
                    err_bl_reg     <= err_last_reg;
                    err_last_reg   <= err_now_reg;
                end
                default:
                    ;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (in_fire)
                begin
                    target_reg <= target_rpm;
                    acc_reg    <= '0;
                    mcand_reg  <= ACC_W'(encoder_count);
                    mplier_reg <= count_to_rpm_reg;
                end
            ST_MEAS:
            begin
                acc_reg    <= acc_step;
                mcand_reg  <= mcand_reg <<< 1;
                mplier_reg <= mplier_reg >> 1;
            end
            ST_ERR:
            begin
                meas_reg    <= meas_sat;
                err_now_reg <= err_calc;
                acc_reg     <= '0;
                mcand_reg   <= ACC_W'(err_calc);
                mplier_reg  <= coef_now_reg;
            end
            ST_PID:
            begin
                acc_reg <= acc_step;
                if (last_bit)
                begin
                    mcand_reg  <= ACC_W'(op_err);
                    mplier_reg <= op_coef;
                end
                else
                begin
                    mcand_reg  <= mcand_reg <<< 1;
                    mplier_reg <= mplier_reg >> 1;
                end
            end
            ST_DRIVE:
                drive_reg <= drive_sat;
            ST_FIN:
                if (slot_free)
                begin
                    if (stop_reg)
                    begin
                        fwd_reg  <= 1'b0;
                        rev_reg  <= 1'b0;
                        duty_reg <= '0;
                        rpm_reg  <= '0;
                    end
                    else
                    begin
                        fwd_reg  <= target_nz && drive_nz && !drive_neg;
                        rev_reg  <= target_nz && !(drive_nz && !drive_neg);
                        duty_reg <= target_nz ? duty_full[DUTY_W-1:0] : '0;
                        rpm_reg  <= meas_reg;
                    end
                end
            default:
                ;
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign drive_fwd    = fwd_reg;
    assign drive_rev    = rev_reg;
    assign pwm_duty     = duty_reg;
    assign measured_rpm = rpm_reg;

    // Never drive both bridge inputs high
    a_dir_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(drive_fwd && drive_rev))
        else $error("both bridge inputs high");

    // Coast beat carries zero duty
    a_coast_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !drive_fwd && !drive_rev) |-> (pwm_duty == '0))
        else $error("nonzero duty while coasting");

    // Stop beat clears the PID history
    a_stop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && cmd[0]) |=>
        (prev_drive_reg == '0 && err_last_reg == '0 && err_bl_reg == '0))
        else $error("stop did not clear PID state");

    // History shifts only once per sample, in the drive step
    a_hist_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRIVE) |=> (err_bl_reg == $past(err_last_reg)))
        else $error("error history shifted wrongly");

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import mspid_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SAMPLE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_STOP   = 1'b1;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 80;      // settle time after the last result, past a full sample schedule
    localparam int CYCLE_LIMIT   = 1200000;
    localparam int MAX_REPORTS   = 10;

    localparam logic [CFG_W-1:0] COEF_MAX = 16'h7FFF;
    localparam logic [CFG_W-1:0] COEF_MIN = 16'h8000;
    localparam logic [CFG_W-1:0] DB_MAX   = 16'h00FF;
    localparam logic [CFG_W-1:0] SCALE_MAX = 16'hFFFF;

    localparam longint DRIVE_HI = 64'sd2147483647;
    localparam longint DRIVE_LO = -DRIVE_HI - 1;

    typedef struct packed {
        logic              fwd;
        logic              rev;
        logic [DUTY_W-1:0] duty;
        logic [RPM_W-1:0]  rpm;
    } bridge_cmd_t;

    logic                    clk;
    logic                    rst_n = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_addr = '0;
    logic [CFG_W-1:0]        cfg_wdata = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [CMD_W-1:0]        cmd = CMD_SAMPLE;
    logic signed [CNT_W-1:0] encoder_count = '0;
    logic signed [RPM_W-1:0] target_rpm = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic                    drive_fwd;
    logic                    drive_rev;
    logic [DUTY_W-1:0]       pwm_duty;
    logic signed [RPM_W-1:0] measured_rpm;

    // Controller copy: registers and PID history
    logic signed [COEF_W-1:0] gain_now = '0;
    logic signed [COEF_W-1:0] gain_last = '0;
    logic signed [COEF_W-1:0] gain_before_last = '0;
    logic [DB_W-1:0]          min_drive = '0;
    logic [SCALE_W-1:0]       rpm_scale = SCALE_RESET;
    longint                   held_drive = 0;
    longint                   err_prev = 0;
    longint                   err_prev2 = 0;

    bridge_cmd_t pending_drive[$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          quiet_mode = 1'b0;

    motor_speed_incremental_pid_top dut (.*);

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("motor_speed_incremental_pid_top regression: fail");
            $finish;
        end
    end

    function automatic longint clamp(longint x, longint lo, longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    function automatic longint pick_between(longint lo, longint hi);
        return lo + longint'($urandom_range(0, 32'(hi - lo)));
    endfunction

    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (quiet_mode || roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 5);
        return $urandom_range(20, 90);
    endfunction

    // One control period of the velocity-form PID; updates the held history
    function automatic bridge_cmd_t predict_pid_step(logic [CMD_W-1:0] op,
                                                     logic signed [CNT_W-1:0] count,
                                                     logic signed [RPM_W-1:0] setpoint);
        bridge_cmd_t r;
        longint      cnt, tgt, scale, meas, err, acc, drv, mag, db, lim;
        r = '0;
        if (op == CMD_STOP) begin
            held_drive = 0;
            err_prev   = 0;
            err_prev2  = 0;
            return r;
        end
        cnt   = count;
        tgt   = setpoint;
        scale = rpm_scale;
        meas  = clamp(cnt * scale, RPM_MIN, RPM_MAX);
        err   = tgt - meas;
        acc   = longint'(gain_now) * err + longint'(gain_last) * err_prev
              + longint'(gain_before_last) * err_prev2;
        drv   = clamp(held_drive + (acc >>> FRAC_BITS), DRIVE_LO, DRIVE_HI);
        held_drive = drv;
        err_prev2  = err_prev;
        err_prev   = err;

        // dead band lift, then duty clamp
        db = min_drive;
        db = db << FRAC_BITS;
        if (drv != 0) begin
            mag = (drv < 0) ? -drv : drv;
            if (mag < db)
                drv = (drv > 0) ? db : -db;
        end
        lim = longint'(DUTY_MAX) << FRAC_BITS;
        drv = clamp(drv, -lim, lim);

        // zero setpoint coasts
        if (setpoint != 0) begin
            mag    = (drv < 0) ? -drv : drv;
            r.duty = DUTY_W'(mag >> FRAC_BITS);
            r.fwd  = (drv > 0);
            r.rev  = !(drv > 0);
        end
        r.rpm = meas[RPM_W-1:0];
        return r;
    endfunction

    // Register write; the copy follows the same decode
    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_COEF_NOW:         gain_now = data;
            REG_COEF_LAST:        gain_last = data;
            REG_COEF_BEFORE_LAST: gain_before_last = data;
            REG_DEAD_BAND:        min_drive = data[DB_W-1:0];
            REG_COUNT_TO_RPM:     rpm_scale = data;
            default: ;
        endcase
    endtask

    task automatic set_gains(logic [CFG_W-1:0] k_now, logic [CFG_W-1:0] k_last,
                             logic [CFG_W-1:0] k_bl, logic [CFG_W-1:0] db,
                             logic [CFG_W-1:0] scale);
        set_reg(REG_COEF_NOW, k_now);
        set_reg(REG_COEF_LAST, k_last);
        set_reg(REG_COEF_BEFORE_LAST, k_bl);
        set_reg(REG_DEAD_BAND, db);
        set_reg(REG_COUNT_TO_RPM, scale);
    endtask

    // Send one beat; called at a clock edge, returns at an edge
    task automatic send_beat(logic [CMD_W-1:0] op, logic signed [CNT_W-1:0] count,
                             logic signed [RPM_W-1:0] setpoint);
        int gap;
        in_valid      <= 1'b1;
        cmd           <= op;
        encoder_count <= count;
        target_rpm    <= setpoint;
        do @(posedge clk); while (!in_ready);
        pending_drive.push_back(predict_pid_step(op, count, setpoint));
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold the sender until every result is back and the block has settled
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_drive.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Count close to what the setpoint asks for, so the loop stays near lock
    task automatic send_tracking_sample();
        longint setpoint, count;
        int     roll;
        roll = $urandom_range(99);
        if (roll < 4) begin
            send_beat(CMD_STOP, CNT_W'($urandom), RPM_W'($urandom));
        end
        else begin
            setpoint = (roll < 10) ? 0 : pick_between(-76800, 76800);
            if (rpm_scale == 0)
                count = pick_between(-50, 50);
            else
                count = setpoint / longint'(rpm_scale) + pick_between(-3, 3);
            count = clamp(count, -32768, 32767);
            send_beat(CMD_SAMPLE, count[CNT_W-1:0], setpoint[RPM_W-1:0]);
        end
    endtask

    task automatic send_noise();
        send_beat(($urandom_range(7) == 0) ? CMD_STOP : CMD_SAMPLE,
                  CNT_W'($urandom), RPM_W'($urandom));
    endtask

    // Defaults after reset: zero gains, saturated speed, stop, zero setpoint
    task automatic test_reset_defaults();
        send_beat(CMD_SAMPLE, '0, 24'h000100);     // zero drive, live setpoint
        send_beat(CMD_SAMPLE, '0, '0);
        send_beat(CMD_SAMPLE, 16'h7FFF, 24'h7FFFFF);
        send_beat(CMD_SAMPLE, 16'h8000, 24'h800000);
        send_beat(CMD_STOP, CNT_W'($urandom), RPM_W'($urandom));
    endtask

    // Unmapped indexes, dead band byte mask, scale extremes
    task automatic test_register_map();
        wait_idle();
        for (int a = int'(REG_COUNT_TO_RPM) + 1; a < (1 << CFG_IDX_W); a++)
            set_reg(CFG_IDX_W'(a), CFG_W'($urandom));
        send_beat(CMD_SAMPLE, 16'sd100, 24'h001000);
        wait_idle();
        set_reg(REG_COEF_NOW, 16'h0100);
        set_reg(REG_DEAD_BAND, 16'hFF03);          // upper byte must be dropped
        set_reg(REG_COUNT_TO_RPM, 16'h0001);
        send_beat(CMD_SAMPLE, '0, 24'h000100);
        send_beat(CMD_SAMPLE, 16'sd5, 24'hFFFF00);
        wait_idle();
        set_reg(REG_COUNT_TO_RPM, SCALE_MAX);
        send_beat(CMD_SAMPLE, 16'sd100, 24'h012345);
        wait_idle();
        set_reg(REG_COUNT_TO_RPM, 16'h0000);
        send_beat(CMD_SAMPLE, CNT_W'($urandom), RPM_W'($urandom));
    endtask

    // Largest errors with largest gains: 32-bit drive saturation both ways
    task automatic test_drive_saturation();
        wait_idle();
        set_gains(COEF_MAX, COEF_MAX, COEF_MAX, '0, SCALE_MAX);
        repeat (3) send_beat(CMD_SAMPLE, 16'h8000, 24'h7FFFFF);
        repeat (3) send_beat(CMD_SAMPLE, 16'h7FFF, 24'h800000);
        wait_idle();
        set_gains(COEF_MIN, COEF_MIN, COEF_MIN, '0, SCALE_MAX);
        repeat (2) send_beat(CMD_SAMPLE, 16'h8000, 24'h7FFFFF);
    endtask

    // Dead band at full scale: tiny drive jumps straight to the clamp
    task automatic test_dead_band_clamp();
        wait_idle();
        set_gains(16'h0001, '0, '0, DB_MAX, SCALE_RESET);
        send_beat(CMD_STOP, '0, '0);
        send_beat(CMD_SAMPLE, '0, 24'h000100);
        send_beat(CMD_SAMPLE, 16'sd2, 24'h000100);
        send_beat(CMD_SAMPLE, '0, 24'hFFFF00);
    endtask

    // Random phases with moderate gains, near-lock samples and some noise
    task automatic test_tracking_loop();
        for (int phase = 0; phase < 9; phase++) begin
            wait_idle();
            set_gains(CFG_W'(pick_between(-700, 700)), CFG_W'(pick_between(-700, 700)),
                      CFG_W'(pick_between(-200, 200)),
                      CFG_W'(($urandom_range(3) == 0) ? 0 : pick_between(1, 30)),
                      CFG_W'(($urandom_range(4) == 0) ? longint'($urandom)
                                                      : pick_between(200, 700)));
            quiet_mode = (phase % 3 == 2);
            for (int n = 0; n < 110; n++) begin
                // one mid-phase hold-off with PID history kept
                if (phase == 1 && n == 55)
                    wait_idle();
                if ($urandom_range(99) < 85)
                    send_tracking_sample();
                else
                    send_noise();
            end
            quiet_mode = 1'b0;
        end
    endtask

    // Register extremes with mixed traffic
    task automatic test_extreme_settings();
        for (int phase = 0; phase < 2; phase++) begin
            wait_idle();
            if (phase == 0)
                set_gains(COEF_MAX, COEF_MIN, COEF_MAX, DB_MAX, SCALE_MAX);
            else
                set_gains(COEF_MIN, COEF_MAX, COEF_MIN, '0, '0);
            for (int n = 0; n < 70; n++) begin
                if ($urandom_range(1) == 0)
                    send_tracking_sample();
                else
                    send_noise();
            end
        end
    endtask

    // Receiver: ready runs broken by random stalls
    initial begin : result_sink
        int run, stall;
        @(posedge rst_n);
        @(posedge clk);
        forever begin
            out_ready <= 1'b1;
            run = $urandom_range(1, 24);
            repeat (run) @(posedge clk);
            stall = pick_gap();
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Each result beat against the oldest prediction
    always @(posedge clk) begin : check_result
        bridge_cmd_t got, want;
        if (rst_n && out_valid && out_ready) begin
            got = {drive_fwd, drive_rev, pwm_duty, measured_rpm};
            if (pending_drive.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: beat with nothing pending: fwd=%0b rev=%0b duty=%0d rpm=%0d",
                             $time, got.fwd, got.rev, got.duty, $signed(got.rpm));
            end
            else begin
                want = pending_drive.pop_front();
                if (got.fwd !== want.fwd || got.rev !== want.rev ||
                    got.duty !== want.duty || got.rpm !== want.rpm) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: expected fwd=%0b rev=%0b duty=%0d rpm=%0d", $time,
                                 want.fwd, want.rev, want.duty, $signed(want.rpm));
                        $display("%0t:      got fwd=%0b rev=%0b duty=%0d rpm=%0d", $time,
                                 got.fwd, got.rev, got.duty, $signed(got.rpm));
                    end
                end
            end
        end
    end

    initial begin : run_tests
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_register_map();
        test_drive_saturation();
        test_dead_band_clamp();
        test_tracking_loop();
        test_extreme_settings();
        wait_idle();
        if (mismatches == 0)
            $display("motor_speed_incremental_pid_top regression: pass");
        else
            $display("motor_speed_incremental_pid_top regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
hdl/mspid_pkg.sv
hdl/motor_speed_incremental_pid_top.sv
bench/tb.sv
